@@ hw/rtl/utmc_pkg.sv @@
package utmc_pkg;

  localparam int TILE_SIZE          = 8;
  localparam int MAX_TILES_PER_SIDE = 128;
  localparam int PIX_W              = 8;
  localparam int ROW_W              = TILE_SIZE * PIX_W;
  localparam int ROW_IDX_W          = $clog2(TILE_SIZE);
  localparam int SEQ_W              = $clog2(TILE_SIZE + 1);
  localparam int TILE_IDX_W         = 14;
  localparam int RAW_CNT_W          = 15;
  localparam int TOTAL_W            = 15;
  localparam int SIDE_W             = 8;

  localparam logic [15:0] UNIFORM_FLAG = 16'h8000;

  // Register index as carried by paddr[2]
  localparam logic REG_TILES_PER_SIDE = 1'b0;

  typedef struct packed {
    logic                  uniform;
    logic [PIX_W-1:0]      value;
    logic [TILE_IDX_W-1:0] tile_idx;
    logic [RAW_CNT_W-1:0]  blk;
  } tile_desc_t;

  typedef struct packed {
    logic                 en;
    logic [ROW_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     row;
    logic                 tile_end;
    tile_desc_t           desc;
  } buf_wr_t;

endpackage

@@ hw/rtl/uniform_tile_map_compressor.sv @@
// Output: a tile's first word is presented once its eighth row is taken, its
//   bank marked full and the word registered; rows before the eighth give no word.
// Throughput: one row per cycle while row_ready is high; a uniform tile gives
//   one word. A raw tile drains nine words at one per cycle from the output
//   register while res_ready is high, so back-to-back raw tiles can hold
//   row_ready low; two tile banks overlap fill and drain.
// Reset (synchronous, rst high): clears counters, banks and output valid;
//   tiles_per_side returns to 128. Tile buffer contents are not cleared.
module uniform_tile_map_compressor (
  input  logic                            clk,
  input  logic                            rst,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // row input
  input  logic                            row_valid,
  output logic                            row_ready,
  input  logic [utmc_pkg::ROW_W-1:0]      row_pixels,
  // result output
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            is_data,
  output logic [utmc_pkg::TILE_IDX_W-1:0] tile_index,
  output logic [15:0]                     table_word,
  output logic [16:0]                     raw_address,
  output logic [utmc_pkg::ROW_W-1:0]      raw_row,
  output logic                            last
);

  localparam logic [utmc_pkg::ROW_IDX_W-1:0] LAST_ROW =
    utmc_pkg::ROW_IDX_W'(utmc_pkg::TILE_SIZE - 1);
  localparam logic [utmc_pkg::SIDE_W-1:0] MAX_SIDE =
    utmc_pkg::SIDE_W'(utmc_pkg::MAX_TILES_PER_SIDE);

  // Registers
  logic [utmc_pkg::SIDE_W-1:0]     tiles_per_side;
  logic [utmc_pkg::ROW_IDX_W-1:0]  row_count;
  logic [utmc_pkg::PIX_W-1:0]      first_pixel;
  logic                            all_equal;
  logic [utmc_pkg::TILE_IDX_W-1:0] tile_count;
  logic [utmc_pkg::RAW_CNT_W-1:0]  raw_count;

  logic [utmc_pkg::TOTAL_W-1:0]    total_tiles;
  logic                            cfg_write;
  logic                            row_acc;
  logic                            tile_done;
  logic [utmc_pkg::PIX_W-1:0]      ref_pixel;
  logic                            row_uniform;
  logic                            tile_uniform;
  logic [utmc_pkg::SIDE_W-1:0]     side_eff;
  logic [2*utmc_pkg::SIDE_W-1:0]   side_sq;
  logic [utmc_pkg::TOTAL_W-1:0]    tile_count_inc;
  logic                            map_wrap;
  logic [utmc_pkg::RAW_CNT_W-1:0]  raw_count_next;
  utmc_pkg::buf_wr_t               wr;

  // APB: zero wait states, register index in paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == utmc_pkg::REG_TILES_PER_SIDE);
  assign prdata    = (paddr[2] == utmc_pkg::REG_TILES_PER_SIDE) ?
                     {24'b0, tiles_per_side} : '0;

  // Clamp the side to 1..MAX and square it for the map wrap compare; the
  // product follows a write at once, so a tile finished right after it
  // already sees the new map size.
  always_comb begin
    if (tiles_per_side == '0) begin
      side_eff = utmc_pkg::SIDE_W'(1);
    end else if (tiles_per_side > MAX_SIDE) begin
      side_eff = MAX_SIDE;
    end else begin
      side_eff = tiles_per_side;
    end
  end
  assign side_sq     = (2*utmc_pkg::SIDE_W)'(side_eff) * (2*utmc_pkg::SIDE_W)'(side_eff);
  assign total_tiles = utmc_pkg::TOTAL_W'(side_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_per_side <= MAX_SIDE;
    end else begin
      if (cfg_write) begin
        tiles_per_side <= pwdata[utmc_pkg::SIDE_W-1:0];
      end
    end
  end

  // Row intake: the first row of a tile supplies the reference pixel, and
  // the byte lanes check every row against it.
  assign row_acc   = row_valid && row_ready;
  assign tile_done = row_acc && (row_count == LAST_ROW);
  assign ref_pixel = (row_count == '0) ? row_pixels[utmc_pkg::PIX_W-1:0] : first_pixel;

  utmc_row_check u_row_check (
    .row         (row_pixels),
    .ref_pixel   (ref_pixel),
    .row_uniform (row_uniform)
  );

  assign tile_uniform = ((row_count == '0) || all_equal) && row_uniform;

  // Map position: wrap both counters once the last tile of the map is done
  assign tile_count_inc = utmc_pkg::TOTAL_W'(tile_count) + utmc_pkg::TOTAL_W'(1);
  assign map_wrap       = (tile_count_inc >= total_tiles);
  assign raw_count_next = tile_uniform ? raw_count : raw_count + utmc_pkg::RAW_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= '0;
      first_pixel <= '0;
      all_equal   <= 1'b1;
      tile_count  <= '0;
      raw_count   <= '0;
    end else if (row_acc) begin
      row_count   <= row_count + utmc_pkg::ROW_IDX_W'(1);
      first_pixel <= ref_pixel;
      all_equal   <= tile_done ? 1'b1 : tile_uniform;
      if (tile_done) begin
        if (map_wrap) begin
          tile_count <= '0;
          raw_count  <= '0;
        end else begin
          tile_count <= utmc_pkg::TILE_IDX_W'(tile_count_inc);
          raw_count  <= raw_count_next;
        end
      end
    end
  end

  // Hand rows and the finished tile's summary to the bank buffer
  always_comb begin
    wr               = '0;
    wr.en            = row_acc;
    wr.idx           = row_count;
    wr.row           = row_pixels;
    wr.tile_end      = tile_done;
    wr.desc.uniform  = tile_uniform;
    wr.desc.value    = ref_pixel;
    wr.desc.tile_idx = tile_count;
    wr.desc.blk      = raw_count;
  end

  utmc_emitter u_emitter (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .ready       (row_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .is_data     (is_data),
    .tile_index  (tile_index),
    .table_word  (table_word),
    .raw_address (raw_address),
    .raw_row     (raw_row),
    .last        (last)
  );

  // A uniform table word always closes its tile
  a_uniform_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_data && table_word[15] |-> last)
    else $error("uniform table word without last");

  // A data word is last exactly when it carries the tile's final row
  a_data_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_data |-> (last == (raw_address[2:0] == LAST_ROW)))
    else $error("last misplaced on raw rows");

  // Table words carry no pixel row
  a_table_row_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_data |-> (raw_row == '0))
    else $error("table word with nonzero raw_row");

  // The row counter returns to zero after a tile's final row
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    tile_done |=> (row_count == '0) && all_equal)
    else $error("tile state not restarted");

endmodule

@@ hw/rtl/utmc_lane.sv @@
module utmc_lane (
  input  logic [utmc_pkg::PIX_W-1:0] pixel,
  input  logic [utmc_pkg::PIX_W-1:0] ref_pixel,
  output logic                       match
);

  assign match = (pixel == ref_pixel);

endmodule

@@ hw/rtl/utmc_row_check.sv @@
module utmc_row_check (
  input  logic [utmc_pkg::ROW_W-1:0] row,
  input  logic [utmc_pkg::PIX_W-1:0] ref_pixel,
  output logic                       row_uniform
);

  logic [utmc_pkg::TILE_SIZE-1:0] lane_match;

  for (genvar g = 0; g < utmc_pkg::TILE_SIZE; g++) begin : g_lane
    utmc_lane u_lane (
      .pixel     (row[g*utmc_pkg::PIX_W +: utmc_pkg::PIX_W]),
      .ref_pixel (ref_pixel),
      .match     (lane_match[g])
    );
  end

  // merge: the row is uniform only if every lane matched
  assign row_uniform = &lane_match;

endmodule

@@ hw/rtl/utmc_emitter.sv @@
module utmc_emitter (
  input  logic                            clk,
  input  logic                            rst,
  input  utmc_pkg::buf_wr_t               wr,
  output logic                            ready,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            is_data,
  output logic [utmc_pkg::TILE_IDX_W-1:0] tile_index,
  output logic [15:0]                     table_word,
  output logic [16:0]                     raw_address,
  output logic [utmc_pkg::ROW_W-1:0]      raw_row,
  output logic                            last
);

  localparam int BUF_DEPTH = 2 * utmc_pkg::TILE_SIZE;
  localparam logic [utmc_pkg::SEQ_W-1:0] LAST_SEQ = utmc_pkg::SEQ_W'(utmc_pkg::TILE_SIZE);

  logic [utmc_pkg::ROW_W-1:0] rows [BUF_DEPTH];
  utmc_pkg::tile_desc_t       desc [2];
  logic [1:0]                 bank_full;
  logic                       wr_bank;
  logic                       rd_bank;
  logic [utmc_pkg::SEQ_W-1:0] seq;

  utmc_pkg::tile_desc_t           cur;
  logic                           adv;
  logic                           emit;
  logic                           word_last;
  logic [utmc_pkg::ROW_IDX_W-1:0] rd_idx;

  assign cur       = desc[rd_bank];
  assign adv       = !res_valid || res_ready;
  assign emit      = adv && bank_full[rd_bank];
  assign word_last = cur.uniform || (seq == LAST_SEQ);
  assign rd_idx    = utmc_pkg::ROW_IDX_W'(seq - utmc_pkg::SEQ_W'(1));
  assign ready     = !bank_full[wr_bank];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rows[{wr_bank, wr.idx}] <= wr.row;
    end
    if (wr.tile_end) begin
      desc[wr_bank] <= wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_full <= '0;
      wr_bank   <= 1'b0;
      rd_bank   <= 1'b0;
      seq       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (wr.tile_end) begin
        bank_full[wr_bank] <= 1'b1;
        wr_bank            <= !wr_bank;
      end
      if (emit) begin
        res_valid <= 1'b1;
        if (word_last) begin
          seq                <= '0;
          bank_full[rd_bank] <= 1'b0;
          rd_bank            <= !rd_bank;
        end else begin
          seq <= seq + utmc_pkg::SEQ_W'(1);
        end
      end else if (adv) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_data    <= (seq != '0);
      tile_index <= cur.tile_idx;
      last       <= word_last;
      if (cur.uniform) begin
        table_word  <= utmc_pkg::UNIFORM_FLAG | {8'b0, cur.value};
        raw_address <= '0;
      end else begin
        table_word  <= {1'b0, cur.blk};
        raw_address <= {cur.blk[13:0], (seq == '0) ? 3'b000 : rd_idx};
      end
      raw_row <= (seq == '0) ? '0 : rows[{rd_bank, rd_idx}];
    end
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import utmc_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;     // the first word of a tile shows only after its eighth row
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on any port
  localparam int N_PROBE        = 24;
  localparam int N_PHASES       = 9;

  localparam logic [ROW_W-1:0] ROW_A5   = 64'hA5A5_A5A5_A5A5_A5A5;
  localparam logic [ROW_W-1:0] ROW_A5_X = 64'h25A5_A5A5_A5A5_A5A5;

  // One result word as it leaves the block.
  typedef struct packed {
    logic                  is_data;
    logic [TILE_IDX_W-1:0] tile_index;
    logic [15:0]           table_word;
    logic [16:0]           raw_address;
    logic [ROW_W-1:0]      raw_row;
    logic                  last;
  } tile_word_t;

  // One row of the directed table. Where known is set, the table word of a
  // finished uniform tile is typed in and replaces the prediction.
  typedef struct packed {
    logic                  known;
    logic [TILE_IDX_W-1:0] tile;
    logic [15:0]           word;
    logic [ROW_W-1:0]      pix;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  row_valid = 1'b0;
  logic                  row_ready;
  logic [ROW_W-1:0]      row_pixels = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b1;
  logic                  is_data;
  logic [TILE_IDX_W-1:0] tile_index;
  logic [15:0]           table_word;
  logic [16:0]           raw_address;
  logic [ROW_W-1:0]      raw_row;
  logic                  last;

  uniform_tile_map_compressor u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row_pixels (row_pixels),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .is_data    (is_data),
    .tile_index (tile_index),
    .table_word (table_word),
    .raw_address(raw_address),
    .raw_row    (raw_row),
    .last       (last)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow of the block: configuration, tile buffer and counters.
  logic [7:0]            side_reg = 8'd128;
  logic [ROW_W-1:0]      tile_buf [TILE_SIZE];
  logic [7:0]            first_px = '0;
  logic                  all_eq = 1'b1;
  logic [2:0]            row_cnt = '0;
  logic [TILE_IDX_W-1:0] tile_cnt = '0;
  logic [RAW_CNT_W-1:0]  raw_cnt = '0;

  tile_word_t pending_words[$];  // words still owed by the block, oldest first
  tile_word_t tile_words[$];     // words caused by the row just taken

  int  errors = 0;
  int  rows_sent = 0;
  int  words_checked = 0;
  int  uniform_tiles = 0;
  int  raw_tiles = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;             // no idling on either side

  probe_row_t probe_rows [N_PROBE] = '{
    // all-zero tile: uniform, value 0x00, first tile of the map
    '{1'b0, 14'd0, 16'h0000, 64'h0}, '{1'b0, 14'd0, 16'h0000, 64'h0},
    '{1'b0, 14'd0, 16'h0000, 64'h0}, '{1'b0, 14'd0, 16'h0000, 64'h0},
    '{1'b0, 14'd0, 16'h0000, 64'h0}, '{1'b0, 14'd0, 16'h0000, 64'h0},
    '{1'b0, 14'd0, 16'h0000, 64'h0}, '{1'b1, 14'd0, 16'h8000, 64'h0},
    // all-ones tile: uniform, value 0xFF
    '{1'b0, 14'd0, 16'h0000, '1}, '{1'b0, 14'd0, 16'h0000, '1},
    '{1'b0, 14'd0, 16'h0000, '1}, '{1'b0, 14'd0, 16'h0000, '1},
    '{1'b0, 14'd0, 16'h0000, '1}, '{1'b0, 14'd0, 16'h0000, '1},
    '{1'b0, 14'd0, 16'h0000, '1}, '{1'b1, 14'd1, 16'h80FF, '1},
    // near miss: only the top bit of the last pixel differs, so raw block 0
    '{1'b0, 14'd0, 16'h0000, ROW_A5}, '{1'b0, 14'd0, 16'h0000, ROW_A5},
    '{1'b0, 14'd0, 16'h0000, ROW_A5}, '{1'b0, 14'd0, 16'h0000, ROW_A5},
    '{1'b0, 14'd0, 16'h0000, ROW_A5}, '{1'b0, 14'd0, 16'h0000, ROW_A5},
    '{1'b0, 14'd0, 16'h0000, ROW_A5}, '{1'b0, 14'd0, 16'h0000, ROW_A5_X}
  };

  // Side settings per random phase: extremes, zero, over the maximum, not a
  // power of two. Phases end at random rows, so some changes land mid-map
  // and mid-tile.
  logic [7:0] side_plan [N_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd4, 8'd255,
                                       8'd3, 8'd8, 8'd2, 8'd128};

  // Advance the shadow by one row; leave the words it causes in tile_words.
  task automatic compress_row(input logic [ROW_W-1:0] pix);
    tile_word_t w;
    int         side;
    tile_words.delete();
    if (row_cnt == 3'd0) first_px = pix[7:0];
    if (pix != {8{first_px}}) all_eq = 1'b0;
    tile_buf[row_cnt] = pix;
    if (row_cnt != 3'(TILE_SIZE - 1)) begin
      row_cnt = row_cnt + 3'd1;
      return;
    end
    w = '0;
    w.tile_index = tile_cnt;
    if (all_eq) begin
      // uniform tile: one table word, nothing in the raw store
      w.table_word = UNIFORM_FLAG | {8'h00, first_px};
      w.last = 1'b1;
      tile_words.push_back(w);
      uniform_tiles++;
    end else begin
      // raw tile: table word with the block number, then the eight rows
      w.table_word = {1'b0, raw_cnt};
      w.raw_address = 17'({raw_cnt, 3'd0});
      tile_words.push_back(w);
      for (int i = 0; i < TILE_SIZE; i++) begin
        w.is_data = 1'b1;
        w.raw_address = 17'({raw_cnt, 3'd0} + i);
        w.raw_row = tile_buf[i];
        w.last = (i == TILE_SIZE - 1);
        tile_words.push_back(w);
      end
      raw_cnt = raw_cnt + 1'b1;
      raw_tiles++;
    end
    // zero counts as one, anything above the maximum saturates
    if (side_reg == 8'd0) side = 1;
    else if (side_reg > MAX_TILES_PER_SIDE) side = MAX_TILES_PER_SIDE;
    else side = int'(side_reg);
    if (int'(tile_cnt) + 1 >= side * side) begin
      tile_cnt = '0;
      raw_cnt = '0;
    end else begin
      tile_cnt = tile_cnt + 1'b1;
    end
    row_cnt = '0;
    all_eq = 1'b1;
  endtask

  // Present one row, hold it until taken, then queue what it owes.
  task automatic offer_row(input logic [ROW_W-1:0] pix, input logic known,
                           input logic [TILE_IDX_W-1:0] tile, input logic [15:0] word);
    tile_word_t w;
    row_pixels <= pix;
    row_valid <= 1'b1;
    @(posedge clk);
    while (!row_ready) @(posedge clk);
    rows_sent++;
    compress_row(pix);
    if (known) begin
      w = '0;
      w.tile_index = tile;
      w.table_word = word;
      w.last = 1'b1;
      pending_words.push_back(w);
    end else begin
      foreach (tile_words[i]) pending_words.push_back(tile_words[i]);
    end
  endtask

  // Drop valid for a random burst, unless the run is in its quiet stretch.
  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      row_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Hold off until every owed word is out and the pipeline has settled.
  task automatic drain_words();
    row_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // edge where the access phase meets pready.
  task automatic write_side(input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TILES_PER_SIDE, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_reg = val;
  endtask

  // Receiver: stall in random bursts, stay ready through the quiet stretch.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ready <= (stall_left == 1);
    end else if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 18);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Compare every word taken against the oldest one owed.
  always @(posedge clk) begin
    tile_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: tile_index %0d table_word %h", tile_index, table_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (is_data !== want.is_data) begin
          $error("is_data: expected %0d, got %0d", want.is_data, is_data);
          errors++;
        end
        if (tile_index !== want.tile_index) begin
          $error("tile_index: expected %0d, got %0d", want.tile_index, tile_index);
          errors++;
        end
        if (table_word !== want.table_word) begin
          $error("table_word: expected %h, got %h", want.table_word, table_word);
          errors++;
        end
        if (raw_address !== want.raw_address) begin
          $error("raw_address: expected %h, got %h", want.raw_address, raw_address);
          errors++;
        end
        if (raw_row !== want.raw_row) begin
          $error("raw_row: expected %h, got %h", want.raw_row, raw_row);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too long with nothing moving.
  always @(posedge clk) begin
    if (rst || psel || (row_valid && row_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               n_rows;
    int               mix;
    logic [7:0]       fill_px;
    int               bad_row;
    int               bad_byte;
    logic [ROW_W-1:0] pix;

    mix = 0;
    fill_px = '0;
    bad_row = 0;
    bad_byte = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset side of 128.
    for (int i = 0; i < N_PROBE; i++) begin
      maybe_pause();
      offer_row(probe_rows[i].pix, probe_rows[i].known, probe_rows[i].tile,
                probe_rows[i].word);
    end

    // Random phases, each under its own side setting; the block is drained
    // before every write, which also pauses the sender until all words are in.
    for (int p = 0; p < N_PHASES; p++) begin
      drain_words();
      write_side(side_plan[p]);
      quiet = (p == N_PHASES - 1);
      n_rows = $urandom_range(10, 22);
      for (int k = 0; k < n_rows; k++) begin
        // pick the flavor of each tile as its first row goes out:
        // uniform, uniform but for one byte, or random noise
        if (row_cnt == 3'd0) begin
          mix = $urandom_range(0, 9);
          fill_px = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) fill_px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          bad_row = $urandom_range(0, TILE_SIZE - 1);
          bad_byte = $urandom_range(0, 7);
        end
        pix = {8{fill_px}};
        if (mix >= 7) begin
          pix = {$urandom, $urandom};
        end else if (mix >= 4 && row_cnt == 3'(bad_row)) begin
          pix = pix ^ (ROW_W'($urandom_range(1, 255)) << (8 * bad_byte));
        end
        maybe_pause();
        offer_row(pix, 1'b0, '0, '0);
      end
    end

    drain_words();
    $display("sent %0d rows: %0d uniform and %0d raw tiles, %0d words checked",
             rows_sent, uniform_tiles, raw_tiles, words_checked);
    $display("covered sides 0 to 255 across %0d settings, with changes mid-map",
             N_PHASES + 1);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/utmc_pkg.sv
hw/rtl/utmc_lane.sv
hw/rtl/utmc_row_check.sv
hw/rtl/utmc_emitter.sv
hw/rtl/uniform_tile_map_compressor.sv
tb/tb_top.sv
